// ===== src/ktca_pkg.sv =====
// shared types, constants and helpers of the constant-acceleration kalman tracker
package ktca_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int EST_W  = 32;
   localparam int COV_W  = 48;
   localparam int CSR_W  = 40;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_POS_VAR       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_VEL_VAR       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_ACC_VAR       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_POS_CROSS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_P0_VEL_ACC_CROSS = 3'd7;

   localparam logic [23:0] RST_STEP_TIME        = 24'd65536;
   localparam logic [39:0] RST_PROCESS_NOISE    = 40'd3277;
   localparam logic [39:0] RST_MEASURE_NOISE    = 40'd327680;
   localparam logic [39:0] RST_P0_POS_VAR       = 40'd6554;
   localparam logic [39:0] RST_P0_VEL_VAR       = 40'd655360000;
   localparam logic [39:0] RST_P0_ACC_VAR       = 40'd6553600;
   localparam logic [39:0] RST_P0_POS_CROSS     = 40'd6554;
   localparam logic [39:0] RST_P0_VEL_ACC_CROSS = 40'd655360;

   // operand and destination codes of the shared multiply-add unit
   localparam logic [4:0] SRC_P0 = 5'd0;
   localparam logic [4:0] SRC_P1 = 5'd1;
   localparam logic [4:0] SRC_P2 = 5'd2;
   localparam logic [4:0] SRC_P3 = 5'd3;
   localparam logic [4:0] SRC_P4 = 5'd4;
   localparam logic [4:0] SRC_P5 = 5'd5;
   localparam logic [4:0] SRC_P6 = 5'd6;
   localparam logic [4:0] SRC_P7 = 5'd7;
   localparam logic [4:0] SRC_P8 = 5'd8;
   localparam logic [4:0] SRC_X0 = 5'd9;
   localparam logic [4:0] SRC_X1 = 5'd10;
   localparam logic [4:0] SRC_X2 = 5'd11;
   localparam logic [4:0] SRC_K0 = 5'd12;
   localparam logic [4:0] SRC_K1 = 5'd13;
   localparam logic [4:0] SRC_K2 = 5'd14;
   localparam logic [4:0] SRC_INNOV = 5'd15;
   localparam logic [4:0] SRC_DT  = 5'd16;
   localparam logic [4:0] SRC_Q   = 5'd17;
   localparam logic [4:0] SRC_ONE = 5'd18;
   localparam logic [4:0] SRC_Y   = 5'd19;

   localparam logic [4:0] OP_INNOV = 5'd18;
   localparam logic [4:0] OP_CORR  = 5'd19;
   localparam logic [4:0] OP_LAST  = 5'd30;

   typedef struct packed {
      logic [4:0] dst;
      logic [4:0] a;
      logic [4:0] b;
      logic [4:0] c;
      logic       sub;
      logic       w32;
   } uop_type;

   // dst = sat(c +/- a*b), one entry per sequencer step
   function automatic uop_type decode(input logic [4:0] op);
      uop_type u;
      case (op)
         5'd0:  u = '{SRC_X0, SRC_DT, SRC_X1, SRC_X0, 1'b0, 1'b1};
         5'd1:  u = '{SRC_X1, SRC_DT, SRC_X2, SRC_X1, 1'b0, 1'b1};
         5'd2:  u = '{SRC_P0, SRC_DT, SRC_P3, SRC_P0, 1'b0, 1'b0};
         5'd3:  u = '{SRC_P1, SRC_DT, SRC_P4, SRC_P1, 1'b0, 1'b0};
         5'd4:  u = '{SRC_P2, SRC_DT, SRC_P5, SRC_P2, 1'b0, 1'b0};
         5'd5:  u = '{SRC_P3, SRC_DT, SRC_P6, SRC_P3, 1'b0, 1'b0};
         5'd6:  u = '{SRC_P4, SRC_DT, SRC_P7, SRC_P4, 1'b0, 1'b0};
         5'd7:  u = '{SRC_P5, SRC_DT, SRC_P8, SRC_P5, 1'b0, 1'b0};
         5'd8:  u = '{SRC_P0, SRC_DT, SRC_P1, SRC_P0, 1'b0, 1'b0};
         5'd9:  u = '{SRC_P3, SRC_DT, SRC_P4, SRC_P3, 1'b0, 1'b0};
         5'd10: u = '{SRC_P6, SRC_DT, SRC_P7, SRC_P6, 1'b0, 1'b0};
         5'd11: u = '{SRC_P1, SRC_DT, SRC_P2, SRC_P1, 1'b0, 1'b0};
         5'd12: u = '{SRC_P4, SRC_DT, SRC_P5, SRC_P4, 1'b0, 1'b0};
         5'd13: u = '{SRC_P7, SRC_DT, SRC_P8, SRC_P7, 1'b0, 1'b0};
         5'd14: u = '{SRC_P0, SRC_Q, SRC_ONE, SRC_P0, 1'b0, 1'b0};
         5'd15: u = '{SRC_P1, SRC_Q, SRC_ONE, SRC_P1, 1'b0, 1'b0};
         5'd16: u = '{SRC_P3, SRC_Q, SRC_ONE, SRC_P3, 1'b0, 1'b0};
         5'd17: u = '{SRC_P4, SRC_Q, SRC_ONE, SRC_P4, 1'b0, 1'b0};
         5'd18: u = '{SRC_INNOV, SRC_X0, SRC_ONE, SRC_Y, 1'b1, 1'b0};
         5'd19: u = '{SRC_X0, SRC_K0, SRC_INNOV, SRC_X0, 1'b0, 1'b1};
         5'd20: u = '{SRC_X1, SRC_K1, SRC_INNOV, SRC_X1, 1'b0, 1'b1};
         5'd21: u = '{SRC_X2, SRC_K2, SRC_INNOV, SRC_X2, 1'b0, 1'b1};
         5'd22: u = '{SRC_P6, SRC_K2, SRC_P0, SRC_P6, 1'b1, 1'b0};
         5'd23: u = '{SRC_P7, SRC_K2, SRC_P1, SRC_P7, 1'b1, 1'b0};
         5'd24: u = '{SRC_P8, SRC_K2, SRC_P2, SRC_P8, 1'b1, 1'b0};
         5'd25: u = '{SRC_P3, SRC_K1, SRC_P0, SRC_P3, 1'b1, 1'b0};
         5'd26: u = '{SRC_P4, SRC_K1, SRC_P1, SRC_P4, 1'b1, 1'b0};
         5'd27: u = '{SRC_P5, SRC_K1, SRC_P2, SRC_P5, 1'b1, 1'b0};
         5'd28: u = '{SRC_P0, SRC_K0, SRC_P0, SRC_P0, 1'b1, 1'b0};
         5'd29: u = '{SRC_P1, SRC_K0, SRC_P1, SRC_P1, 1'b1, 1'b0};
         5'd30: u = '{SRC_P2, SRC_K0, SRC_P2, SRC_P2, 1'b1, 1'b0};
         default: u = '{SRC_P0, SRC_P0, SRC_P0, SRC_P0, 1'b0, 1'b0};
      endcase
      return u;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > 50'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
      else if (v < -50'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
      else r = v[47:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat32(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > 50'sh0_0000_7FFF_FFFF) r = 48'sh0000_7FFF_FFFF;
      else if (v < -50'sh0_0000_8000_0000) r = -48'sh0000_8000_0000;
      else r = v[47:0];
      return r;
   endfunction

endpackage

// ===== src/ktca_if.sv =====
// request and response channel interfaces of the kalman tracker
interface ktca_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] sample;
   modport source (output valid, kind, sample, input ready);
   modport sink (input valid, kind, sample, output ready);
endinterface

interface ktca_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic signed [31:0] position_est;
   logic signed [31:0] velocity_est;
   logic signed [31:0] accel_est;
   modport source (output valid, status, position_est, velocity_est, accel_est, input ready);
   modport sink (input valid, status, position_est, velocity_est, accel_est, output ready);
endinterface

// ===== src/kalman_tracker_const_accel.sv =====
// one-axis constant-acceleration kalman tracker top level
// A restart transaction, and a measurement before any restart, answer without any arithmetic.
// A measurement transaction runs 31 multiply-add steps through one shared
// 24x24 multiplier (four partial products per step) plus, when the denominator is positive,
// three restoring divisions on one shared divider; the next transaction is taken once the
// result is taken.
module kalman_tracker_const_accel #(
   parameter int FRACTION_BITS = ktca_pkg::FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ktca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ktca_pkg::CSR_W-1:0]      csr_wdata,
   ktca_req_if.sink                        req_chan,
   ktca_rsp_if.source                      rsp_chan
);

   localparam int DIV_W = 48 + FRACTION_BITS;
   localparam int CNT_W = $clog2(DIV_W);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_WB    = 4'd3;
   localparam logic [3:0] S_DEN   = 4'd4;
   localparam logic [3:0] S_DLOAD = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_KWB   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [4:0]  op_ff, op_in;
   logic [1:0]  gi_ff, gi_in;
   logic [1:0]  pp_ff, pp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [23:0] dt_ff, dt_in;
   logic [39:0] q_ff, q_in, r_ff, r_in;
   logic [39:0] p0pv_ff, p0pv_in, p0vv_ff, p0vv_in, p0av_ff, p0av_in;
   logic [39:0] p0pc_ff, p0pc_in, p0vac_ff, p0vac_in;

   logic signed [47:0] p_ff [9];
   logic signed [47:0] p_in [9];
   logic signed [31:0] x_ff [3];
   logic signed [31:0] x_in [3];
   logic signed [47:0] k_ff [3];
   logic signed [47:0] k_in [3];
   logic signed [47:0] innov_ff, innov_in;
   logic signed [31:0] y_ff, y_in;
   logic        ready_flag_ff, ready_flag_in;
   logic        status_ff, status_in;

   logic [47:0] am_ff, am_in, bm_ff, bm_in;
   logic        neg_ff, neg_in;
   logic signed [47:0] c_ff, c_in;
   logic [95:0] acc_ff, acc_in;

   logic signed [49:0] den_ff, den_in;
   logic [49:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]   dv_ff, dv_in;
   logic               dneg_ff, dneg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in, rsp_acc_ff, rsp_acc_in;

   ktca_pkg::uop_type  uop;
   logic signed [47:0] opa, opb, opc;
   logic [23:0]        ha, hb;
   logic [47:0]        pp;
   logic [95:0]        pp_sh;
   logic [95:0]        prod_sh;
   logic signed [49:0] fv, sum;
   logic signed [47:0] res;
   logic [49:0]        dsh;
   logic               qbit;
   logic               den_pos;
   logic signed [47:0] num;
   logic signed [47:0] kval;

   function automatic logic signed [47:0] rd(input logic [4:0] code,
                                             input logic signed [47:0] pv [9],
                                             input logic signed [31:0] xv [3],
                                             input logic signed [47:0] kv [3],
                                             input logic signed [47:0] iv,
                                             input logic [23:0] dtv,
                                             input logic [39:0] qv,
                                             input logic signed [31:0] yv);
      logic signed [47:0] v;
      case (code)
         ktca_pkg::SRC_P0:    v = pv[0];
         ktca_pkg::SRC_P1:    v = pv[1];
         ktca_pkg::SRC_P2:    v = pv[2];
         ktca_pkg::SRC_P3:    v = pv[3];
         ktca_pkg::SRC_P4:    v = pv[4];
         ktca_pkg::SRC_P5:    v = pv[5];
         ktca_pkg::SRC_P6:    v = pv[6];
         ktca_pkg::SRC_P7:    v = pv[7];
         ktca_pkg::SRC_P8:    v = pv[8];
         ktca_pkg::SRC_X0:    v = 48'(xv[0]);
         ktca_pkg::SRC_X1:    v = 48'(xv[1]);
         ktca_pkg::SRC_X2:    v = 48'(xv[2]);
         ktca_pkg::SRC_K0:    v = kv[0];
         ktca_pkg::SRC_K1:    v = kv[1];
         ktca_pkg::SRC_K2:    v = kv[2];
         ktca_pkg::SRC_INNOV: v = iv;
         ktca_pkg::SRC_DT:    v = $signed({24'd0, dtv});
         ktca_pkg::SRC_Q:     v = $signed({8'd0, qv});
         ktca_pkg::SRC_ONE:   v = 48'sd1 <<< FRACTION_BITS;
         ktca_pkg::SRC_Y:     v = 48'(yv);
         default:             v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      uop = ktca_pkg::decode(op_ff);
      opa = rd(uop.a, p_ff, x_ff, k_ff, innov_ff, dt_ff, q_ff, y_ff);
      opb = rd(uop.b, p_ff, x_ff, k_ff, innov_ff, dt_ff, q_ff, y_ff);
      opc = rd(uop.c, p_ff, x_ff, k_ff, innov_ff, dt_ff, q_ff, y_ff);

      // partial products of the shared multiplier
      ha = pp_ff[0] ? am_ff[47:24] : am_ff[23:0];
      hb = pp_ff[1] ? bm_ff[47:24] : bm_ff[23:0];
      pp = 48'(ha * hb);
      case (pp_ff)
         2'd0:    pp_sh = {48'd0, pp};
         2'd3:    pp_sh = {pp, 48'd0};
         default: pp_sh = {24'd0, pp, 24'd0};
      endcase

      // truncate, saturate and accumulate
      prod_sh = acc_ff >> FRACTION_BITS;
      if (|prod_sh[95:47]) begin
         fv = neg_ff ? -50'sh0_8000_0000_0000 : 50'sh0_7FFF_FFFF_FFFF;
      end else begin
         fv = neg_ff ? -$signed({3'd0, prod_sh[46:0]}) : $signed({3'd0, prod_sh[46:0]});
      end
      sum = 50'(c_ff) + (uop.sub ? -fv : fv);
      res = uop.w32 ? ktca_pkg::sat32(sum) : ktca_pkg::sat48(sum);

      // divider step
      dsh  = {rem_ff[48:0], dv_ff[DIV_W-1]};
      qbit = (dsh >= $unsigned(den_ff));
      den_pos = !den_ff[49] && (|den_ff);
      case (gi_ff)
         2'd1:    num = p_ff[3];
         2'd2:    num = p_ff[6];
         default: num = p_ff[0];
      endcase
      if (|dv_ff[DIV_W-1:47]) begin
         kval = dneg_ff ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end else begin
         kval = dneg_ff ? -$signed({1'b0, dv_ff[46:0]}) : $signed({1'b0, dv_ff[46:0]});
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      gi_in = gi_ff;
      pp_in = pp_ff;
      cnt_in = cnt_ff;
      dt_in = dt_ff;
      q_in = q_ff;
      r_in = r_ff;
      p0pv_in = p0pv_ff;
      p0vv_in = p0vv_ff;
      p0av_in = p0av_ff;
      p0pc_in = p0pc_ff;
      p0vac_in = p0vac_ff;
      p_in = p_ff;
      x_in = x_ff;
      k_in = k_ff;
      innov_in = innov_ff;
      y_in = y_ff;
      ready_flag_in = ready_flag_ff;
      status_in = status_ff;
      am_in = am_ff;
      bm_in = bm_ff;
      neg_in = neg_ff;
      c_in = c_ff;
      acc_in = acc_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      dv_in = dv_ff;
      dneg_in = dneg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      rsp_acc_in = rsp_acc_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            ktca_pkg::CSR_STEP_TIME:        dt_in = csr_wdata[23:0];
            ktca_pkg::CSR_PROCESS_NOISE:    q_in = csr_wdata;
            ktca_pkg::CSR_MEASURE_NOISE:    r_in = csr_wdata;
            ktca_pkg::CSR_P0_POS_VAR:       p0pv_in = csr_wdata;
            ktca_pkg::CSR_P0_VEL_VAR:       p0vv_in = csr_wdata;
            ktca_pkg::CSR_P0_ACC_VAR:       p0av_in = csr_wdata;
            ktca_pkg::CSR_P0_POS_CROSS:     p0pc_in = csr_wdata;
            ktca_pkg::CSR_P0_VEL_ACC_CROSS: p0vac_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               y_in = req_chan.sample;
               status_in = 1'b0;
               op_in = '0;
               if (req_chan.kind) begin
                  x_in[0] = req_chan.sample;
                  x_in[1] = '0;
                  x_in[2] = '0;
                  p_in[0] = $signed({8'd0, p0pv_ff});
                  p_in[1] = 48'($signed(p0pc_ff));
                  p_in[2] = 48'($signed(p0pc_ff));
                  p_in[3] = 48'($signed(p0pc_ff));
                  p_in[4] = $signed({8'd0, p0vv_ff});
                  p_in[5] = 48'($signed(p0vac_ff));
                  p_in[6] = 48'($signed(p0pc_ff));
                  p_in[7] = 48'($signed(p0vac_ff));
                  p_in[8] = $signed({8'd0, p0av_ff});
                  ready_flag_in = 1'b1;
                  state_in = S_OUT;
               end else if (!ready_flag_ff) begin
                  status_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            am_in = opa[47] ? 48'(-opa) : opa;
            bm_in = opb[47] ? 48'(-opb) : opb;
            neg_in = opa[47] ^ opb[47];
            c_in = opc;
            acc_in = '0;
            pp_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = acc_ff + pp_sh;
            pp_in = pp_ff + 2'd1;
            if (pp_ff == 2'd3) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            case (uop.dst)
               ktca_pkg::SRC_P0:    p_in[0] = res;
               ktca_pkg::SRC_P1:    p_in[1] = res;
               ktca_pkg::SRC_P2:    p_in[2] = res;
               ktca_pkg::SRC_P3:    p_in[3] = res;
               ktca_pkg::SRC_P4:    p_in[4] = res;
               ktca_pkg::SRC_P5:    p_in[5] = res;
               ktca_pkg::SRC_P6:    p_in[6] = res;
               ktca_pkg::SRC_P7:    p_in[7] = res;
               ktca_pkg::SRC_P8:    p_in[8] = res;
               ktca_pkg::SRC_X0:    x_in[0] = res[31:0];
               ktca_pkg::SRC_X1:    x_in[1] = res[31:0];
               ktca_pkg::SRC_X2:    x_in[2] = res[31:0];
               ktca_pkg::SRC_INNOV: innov_in = res;
               default: ;
            endcase
            op_in = op_ff + 5'd1;
            if (op_ff == ktca_pkg::OP_INNOV) begin
               state_in = S_DEN;
            end else if (op_ff == ktca_pkg::OP_LAST) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_DEN: begin
            den_in = 50'(p_ff[0]) + $signed({10'd0, r_ff});
            gi_in = '0;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            if (!den_pos) begin
               k_in[gi_ff] = '0;
               gi_in = gi_ff + 2'd1;
               if (gi_ff == 2'd2) begin
                  op_in = ktca_pkg::OP_CORR;
                  state_in = S_LOAD;
               end
            end else begin
               dv_in = DIV_W'(num[47] ? 48'(-num) : num) << FRACTION_BITS;
               dneg_in = num[47];
               rem_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = qbit ? dsh - $unsigned(den_ff) : dsh;
            dv_in = {dv_ff[DIV_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = S_KWB;
            end
         end
         S_KWB: begin
            k_in[gi_ff] = kval;
            gi_in = gi_ff + 2'd1;
            if (gi_ff == 2'd2) begin
               op_in = ktca_pkg::OP_CORR;
               state_in = S_LOAD;
            end else begin
               state_in = S_DLOAD;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_pos_in = x_ff[0];
            rsp_vel_in = x_ff[1];
            rsp_acc_in = x_ff[2];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= '0;
         gi_ff <= '0;
         pp_ff <= '0;
         cnt_ff <= '0;
         dt_ff <= ktca_pkg::RST_STEP_TIME;
         q_ff <= ktca_pkg::RST_PROCESS_NOISE;
         r_ff <= ktca_pkg::RST_MEASURE_NOISE;
         p0pv_ff <= ktca_pkg::RST_P0_POS_VAR;
         p0vv_ff <= ktca_pkg::RST_P0_VEL_VAR;
         p0av_ff <= ktca_pkg::RST_P0_ACC_VAR;
         p0pc_ff <= ktca_pkg::RST_P0_POS_CROSS;
         p0vac_ff <= ktca_pkg::RST_P0_VEL_ACC_CROSS;
         p_ff <= '{default: '0};
         x_ff <= '{default: '0};
         ready_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         gi_ff <= gi_in;
         pp_ff <= pp_in;
         cnt_ff <= cnt_in;
         dt_ff <= dt_in;
         q_ff <= q_in;
         r_ff <= r_in;
         p0pv_ff <= p0pv_in;
         p0vv_ff <= p0vv_in;
         p0av_ff <= p0av_in;
         p0pc_ff <= p0pc_in;
         p0vac_ff <= p0vac_in;
         p_ff <= p_in;
         x_ff <= x_in;
         ready_flag_ff <= ready_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      innov_ff <= innov_in;
      y_ff <= y_in;
      status_ff <= status_in;
      am_ff <= am_in;
      bm_ff <= bm_in;
      neg_ff <= neg_in;
      c_ff <= c_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dv_ff <= dv_in;
      dneg_ff <= dneg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.position_est = rsp_pos_ff;
   assign rsp_chan.velocity_est = rsp_vel_ff;
   assign rsp_chan.accel_est = rsp_acc_ff;

endmodule

// ===== src/ktca_checker.sv =====
// port-level checks of the kalman tracker and their binding
module ktca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [31:0] rsp_pos,
   input logic [31:0] rsp_vel,
   input logic [31:0] rsp_acc
);

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request transaction");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a response was pending");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_pos)
         && $stable(rsp_vel) && $stable(rsp_acc))
      else $error("stalled response changed");

endmodule

bind kalman_tracker_const_accel ktca_checker u_ktca_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_pos(rsp_chan.position_est),
   .rsp_vel(rsp_chan.velocity_est),
   .rsp_acc(rsp_chan.accel_est)
);

// ===== tb/tb_kalman_tracker_const_accel.sv =====
// self-checking testbench of the constant-acceleration kalman tracker
`timescale 1ns / 100ps

module tb_kalman_tracker_const_accel;

   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        kind;
      logic [31:0] sample;
   } track_item_type;

   typedef struct {
      logic        status;
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] acc;
   } estimate_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ktca_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ktca_pkg::CSR_W-1:0] csr_wdata;

   ktca_req_if req_bus();
   ktca_rsp_if rsp_bus();

   kalman_tracker_const_accel dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source)
   );

   // tracker model state and register copies
   logic [23:0] m_dt;
   logic [39:0] m_q, m_r, m_pv, m_vv, m_av, m_pc, m_vac;
   longint m_x[3];
   longint m_p[9];
   bit m_ready;

   track_item_type stim_q[$];
   estimate_type est_q[$];
   int errs;
   int cycles;
   bit hold_tx;

   function automatic longint sat_to(longint v, int w);
      longint lim;
      lim = (longint'(1) <<< (w - 1)) - 1;
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   function automatic logic [63:0] magnitude(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   function automatic longint fx_mul(longint a, longint b, int w);
      logic [127:0] pr;
      longint lim;
      bit neg;
      neg = (a < 0) != (b < 0);
      lim = (longint'(1) <<< (w - 1)) - 1;
      pr = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      pr = pr >> ktca_pkg::FRACTION_BITS;
      if (pr > 128'(lim)) return neg ? -lim - 1 : lim;
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   function automatic longint fx_gain(longint num, longint den);
      logic [127:0] qt;
      longint lim;
      lim = (longint'(1) <<< 47) - 1;
      qt = ({64'd0, magnitude(num)} << ktca_pkg::FRACTION_BITS) / {64'd0, den};
      if (qt > 128'(lim)) return num < 0 ? -lim - 1 : lim;
      return num < 0 ? -longint'(qt[63:0]) : longint'(qt[63:0]);
   endfunction

   function automatic void track_measure(longint y);
      longint dt, den, innov;
      longint x[3], mm[9], pp[9], kk[3];
      dt = longint'(m_dt);
      x[0] = sat_to(m_x[0] + fx_mul(dt, m_x[1], 48), 32);
      x[1] = sat_to(m_x[1] + fx_mul(dt, m_x[2], 48), 32);
      x[2] = m_x[2];
      for (int j = 0; j < 3; j++) begin
         mm[j] = sat_to(m_p[j] + fx_mul(dt, m_p[3 + j], 48), 48);
         mm[3 + j] = sat_to(m_p[3 + j] + fx_mul(dt, m_p[6 + j], 48), 48);
         mm[6 + j] = m_p[6 + j];
      end
      for (int i = 0; i < 3; i++) begin
         pp[i*3] = sat_to(mm[i*3] + fx_mul(dt, mm[i*3+1], 48), 48);
         pp[i*3+1] = sat_to(mm[i*3+1] + fx_mul(dt, mm[i*3+2], 48), 48);
         pp[i*3+2] = mm[i*3+2];
      end
      pp[0] = sat_to(pp[0] + longint'(m_q), 48);
      pp[1] = sat_to(pp[1] + longint'(m_q), 48);
      pp[3] = sat_to(pp[3] + longint'(m_q), 48);
      pp[4] = sat_to(pp[4] + longint'(m_q), 48);
      den = pp[0] + longint'(m_r);
      for (int i = 0; i < 3; i++) kk[i] = den > 0 ? fx_gain(pp[i*3], den) : 0;
      innov = y - x[0];
      for (int i = 0; i < 3; i++) m_x[i] = sat_to(x[i] + fx_mul(kk[i], innov, 48), 32);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m_p[i*3+j] = sat_to(pp[i*3+j] - fx_mul(kk[i], pp[j], 48), 48);
   endfunction

   function automatic estimate_type track_step(logic kind, logic [31:0] sample);
      estimate_type e;
      longint y, c, va;
      y = longint'(signed'(sample));
      c = longint'(signed'(m_pc));
      va = longint'(signed'(m_vac));
      e.status = 1'b0;
      if (kind) begin
         m_x[0] = y; m_x[1] = 0; m_x[2] = 0;
         m_p[0] = longint'(m_pv); m_p[1] = c; m_p[2] = c;
         m_p[3] = c; m_p[4] = longint'(m_vv); m_p[5] = va;
         m_p[6] = c; m_p[7] = va; m_p[8] = longint'(m_av);
         m_ready = 1'b1;
      end else if (!m_ready) begin
         e.status = 1'b1;
      end else begin
         track_measure(y);
      end
      e.pos = m_x[0][31:0];
      e.vel = m_x[1][31:0];
      e.acc = m_x[2][31:0];
      return e;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // sender: bursts of random length with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      track_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            est_q.push_back(track_step(req_bus.kind, req_bus.sample));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (stim_q.size() > 0 && !hold_tx) begin
               it = stim_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.kind <= it.kind;
               req_bus.sample <= it.sample;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern follows bits 9:8 of the cycle counter
   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (est_q.size() == 0) begin
               $error("response transaction with nothing expected");
               errs++;
            end else begin
               e = est_q.pop_front();
               if (rsp_bus.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_bus.status);
                  errs++;
               end
               if (rsp_bus.position_est !== e.pos) begin
                  $error("position_est: expected %0d, actual %0d",
                         signed'(e.pos), rsp_bus.position_est);
                  errs++;
               end
               if (rsp_bus.velocity_est !== e.vel) begin
                  $error("velocity_est: expected %0d, actual %0d",
                         signed'(e.vel), rsp_bus.velocity_est);
                  errs++;
               end
               if (rsp_bus.accel_est !== e.acc) begin
                  $error("accel_est: expected %0d, actual %0d",
                         signed'(e.acc), rsp_bus.accel_est);
                  errs++;
               end
            end
         end
         case (cycles[9:8])
            2'd0: rsp_bus.ready <= 1'b1;
            2'd1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic add_item(logic kind, logic [31:0] sample);
      track_item_type it;
      it.kind = kind;
      it.sample = sample;
      stim_q.push_back(it);
   endtask

   task automatic csr_write(logic [ktca_pkg::CSR_IDX_W-1:0] idx,
                            logic [ktca_pkg::CSR_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         ktca_pkg::CSR_STEP_TIME:        m_dt = v[23:0];
         ktca_pkg::CSR_PROCESS_NOISE:    m_q = v;
         ktca_pkg::CSR_MEASURE_NOISE:    m_r = v;
         ktca_pkg::CSR_P0_POS_VAR:       m_pv = v;
         ktca_pkg::CSR_P0_VEL_VAR:       m_vv = v;
         ktca_pkg::CSR_P0_ACC_VAR:       m_av = v;
         ktca_pkg::CSR_P0_POS_CROSS:     m_pc = v;
         default:                        m_vac = v;
      endcase
   endtask

   task automatic drain();
      do @(posedge clock);
      while (stim_q.size() != 0 || req_bus.valid || est_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [39:0] rand40();
      case ($urandom_range(0, 3))
         0: return 40'($urandom_range(0, 65535));
         1: return 40'($urandom_range(0, 32'h00FF_FFFF));
         2: return {8'($urandom), 32'($urandom)};
         default: return 40'($urandom);
      endcase
   endfunction

   task automatic add_tracks(int n);
      int made;
      logic [31:0] pos, vel;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(1'($urandom_range(0, 1)), $urandom);
            made++;
         end else begin
            pos = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 32'h00FF_FFFF));
            vel = 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
            add_item(1'b1, pos);
            made++;
            repeat ($urandom_range(0, 14)) begin
               pos = pos + vel + 32'($urandom_range(0, 32'h0000_FFFF)) - 32'h0000_8000;
               add_item(1'b0, pos);
               made++;
            end
         end
      end
   endtask

   initial begin
      m_dt = ktca_pkg::RST_STEP_TIME;
      m_q = ktca_pkg::RST_PROCESS_NOISE;
      m_r = ktca_pkg::RST_MEASURE_NOISE;
      m_pv = ktca_pkg::RST_P0_POS_VAR;
      m_vv = ktca_pkg::RST_P0_VEL_VAR;
      m_av = ktca_pkg::RST_P0_ACC_VAR;
      m_pc = ktca_pkg::RST_P0_POS_CROSS;
      m_vac = ktca_pkg::RST_P0_VEL_ACC_CROSS;
      for (int i = 0; i < 3; i++) m_x[i] = 0;
      for (int i = 0; i < 9; i++) m_p[i] = 0;
      m_ready = 1'b0;
      errs = 0;
      cycles = 0;
      hold_tx = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // measurements before any restart, then saturation corners
      add_item(1'b0, 32'h7FFF_FFFF);
      add_item(1'b0, 32'h8000_0000);
      add_item(1'b1, 32'h0000_0000);
      add_item(1'b0, 32'h0064_0000);
      add_item(1'b0, 32'h00C8_0000);
      add_item(1'b0, 32'h012C_0000);
      add_item(1'b1, 32'h7FFF_FFFF);
      add_item(1'b0, 32'h8000_0000);
      add_item(1'b0, 32'h8000_0000);
      add_item(1'b1, 32'h8000_0000);
      add_item(1'b0, 32'h7FFF_FFFF);
      add_item(1'b0, 32'h7FFF_FFFF);
      add_item(1'b1, 32'h1234_5678);
      add_item(1'b0, 32'hFFFF_FFFF);
      add_item(1'b0, 32'h0000_0001);
      add_item(1'b0, 32'h1234_5678);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               csr_write(ktca_pkg::CSR_STEP_TIME, 40'hFF_FFFF);
               csr_write(ktca_pkg::CSR_PROCESS_NOISE, 40'hFF_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_MEASURE_NOISE, 40'hFF_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_POS_VAR, 40'hFF_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_VEL_VAR, 40'hFF_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_ACC_VAR, 40'hFF_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_POS_CROSS, 40'h7F_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_VEL_ACC_CROSS, 40'h80_0000_0000);
            end
            1: begin
               // zero denominator
               csr_write(ktca_pkg::CSR_STEP_TIME, 40'h0);
               csr_write(ktca_pkg::CSR_PROCESS_NOISE, 40'h0);
               csr_write(ktca_pkg::CSR_MEASURE_NOISE, 40'h0);
               csr_write(ktca_pkg::CSR_P0_POS_VAR, 40'h0);
               csr_write(ktca_pkg::CSR_P0_VEL_VAR, 40'h0);
               csr_write(ktca_pkg::CSR_P0_ACC_VAR, 40'h0);
               csr_write(ktca_pkg::CSR_P0_POS_CROSS, 40'h0);
               csr_write(ktca_pkg::CSR_P0_VEL_ACC_CROSS, 40'h0);
            end
            2: begin
               // negative predicted position variance
               csr_write(ktca_pkg::CSR_STEP_TIME, 40'hFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_POS_CROSS, 40'h80_0000_0000);
               csr_write(ktca_pkg::CSR_P0_VEL_ACC_CROSS, 40'h7F_FFFF_FFFF);
               csr_write(ktca_pkg::CSR_P0_VEL_VAR, 40'h0);
            end
            default: begin
               csr_write(ktca_pkg::CSR_STEP_TIME, ($urandom_range(0, 3) == 0) ?
                         40'($urandom_range(0, 24'hFF_FFFF)) : 40'($urandom_range(0, 24'h04_0000)));
               csr_write(ktca_pkg::CSR_PROCESS_NOISE, rand40());
               csr_write(ktca_pkg::CSR_MEASURE_NOISE, rand40());
               csr_write(ktca_pkg::CSR_P0_POS_VAR, rand40());
               csr_write(ktca_pkg::CSR_P0_VEL_VAR, rand40());
               csr_write(ktca_pkg::CSR_P0_ACC_VAR, rand40());
               csr_write(ktca_pkg::CSR_P0_POS_CROSS, rand40());
               csr_write(ktca_pkg::CSR_P0_VEL_ACC_CROSS, rand40());
            end
         endcase
         @(posedge clock);
         csr_we <= 1'b0;
         if (ph == 5) begin
            // split the phase: queue half the items, drain until every response is back, then queue the rest
            hold_tx = 1'b1;
            add_tracks(70);
            hold_tx = 1'b0;
            drain();
            add_tracks(70);
         end else begin
            add_tracks(140);
         end
         drain();
      end

      if (errs == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
